/* src/csn_pkg.sv */
// Shared types and constants for the channel sequence numberer.
`default_nettype none
package csn_pkg;

  localparam int SEQ_W   = 16;
  localparam int ORDER_W = 32;
  localparam int CHAN_W  = 4;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // One channel's counter pair as held in the channel memory.
  typedef struct packed {
    logic [SEQ_W-1:0] rel;
    logic [SEQ_W-1:0] unrel;
  } entry_t;

  // Write-back request into the channel memory (address travels separately).
  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_req_t;

endpackage
`default_nettype wire

/* src/csn_chan_mem.sv */
// Per-channel counter memory with registered reads and valid bits.
`default_nettype none
module csn_chan_mem #(
  parameter int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output csn_pkg::entry_t         rd_data,
  input  wire csn_pkg::wr_req_t   wr,
  input  wire logic [IDX_W-1:0]   wr_addr
);
  import csn_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld;
  entry_t           rd_raw;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit <= vld[rd_addr];
    end
  end

  // an entry never written reads as zero
  assign rd_data = rd_hit ? rd_raw : '0;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr.en && rd_en))
    else $error("channel memory read and write in the same cycle");
`endif

endmodule
`default_nettype wire

/* src/channel_sequence_numberer.sv */
// An accepted request is captured with its channel memory read and worked out in the calc state.
// A request is taken only when the last is through: channel memory read, then write-back.
// The result goes to the output register once that register is free; the next request is taken
// while a finished result waits there. Reset: synchronous; clears the peer-wide counters and
// the channel valid bits at once, so requests are taken right after reset with no clearing pass.
`default_nettype none
module channel_sequence_numberer #(
  parameter int CHANNEL_COUNT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          is_control,
  input  wire logic [csn_pkg::CHAN_W-1:0]    channel,
  input  wire logic                          wants_ack,
  input  wire logic                          unsequenced,
  input  wire logic                          first_fragment,
  input  wire logic                          carries_packet,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [csn_pkg::SEQ_W-1:0]          reliable_seq,
  output logic [csn_pkg::SEQ_W-1:0]          unreliable_seq,
  output logic [csn_pkg::SEQ_W-1:0]          unsequenced_group,
  output logic                               to_reliable_queue,
  output logic [csn_pkg::ORDER_W-1:0]        queue_order
);
  import csn_pkg::*;

  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [8:0] CNT = 9'(CHANNEL_COUNT);

  state_t state, state_next;

  // captured request
  logic             r_ctl, r_ack, r_unseq, r_first, r_pkt, r_ok;
  logic [IDX_W-1:0] r_idx;

  // peer-wide counters
  logic [SEQ_W-1:0]   ctl_rel, ctl_rel_next;
  logic [SEQ_W-1:0]   grp, grp_next;
  logic [ORDER_W-1:0] order_cnt, order_cnt_next;

  logic                 accept, calc_done;
  logic [IDX_W+3:0]     ch_wide;
  logic [IDX_W-1:0]     ch_idx;
  logic                 ch_ok;
  entry_t               entry;
  wr_req_t              wr;
  logic [SEQ_W-1:0]     rel_val, unrel_val;
  logic                 out_valid_next;

  assign ch_wide = {{IDX_W{1'b0}}, channel};
  assign ch_idx  = ch_wide[IDX_W-1:0];
  assign ch_ok   = {5'b0, channel} < CNT;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign calc_done = (state == ST_CALC) && (!out_valid || out_ready);

  csn_chan_mem #(.DEPTH(CHANNEL_COUNT)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ch_idx),
    .rd_data (entry),
    .wr      (wr),
    .wr_addr (r_idx)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      r_ctl   <= is_control;
      r_ack   <= wants_ack;
      r_unseq <= unsequenced;
      r_first <= first_fragment;
      r_pkt   <= carries_packet;
      r_ok    <= ch_ok;
      r_idx   <= ch_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ctl_rel   <= '0;
      grp       <= '0;
      order_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ctl_rel   <= ctl_rel_next;
      grp       <= grp_next;
      order_cnt <= order_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl_rel_next   = ctl_rel;
    grp_next       = grp;
    order_cnt_next = order_cnt;
    rel_val        = '0;
    unrel_val      = '0;
    wr.en          = 1'b0;
    wr.data        = entry;
    out_valid_next = out_valid && !out_ready;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_done) begin
          state_next     = ST_IDLE;
          out_valid_next = 1'b1;
          order_cnt_next = order_cnt + 1'b1;
          priority if (r_ctl) begin
            ctl_rel_next = ctl_rel + 1'b1;
            rel_val      = ctl_rel_next;
          end else if (r_ack) begin
            if (r_ok) begin
              wr.en         = 1'b1;
              wr.data.rel   = entry.rel + 1'b1;
              wr.data.unrel = '0;
              rel_val       = wr.data.rel;
            end
          end else if (r_unseq) begin
            grp_next = grp + 1'b1;
          end else if (r_ok) begin
            // unreliable count advances on the first fragment only
            wr.en         = r_first;
            wr.data.unrel = r_first ? entry.unrel + 1'b1 : entry.unrel;
            rel_val       = entry.rel;
            unrel_val     = wr.data.unrel;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (calc_done) begin
      reliable_seq      <= rel_val;
      unreliable_seq    <= unrel_val;
      unsequenced_group <= grp_next;
      to_reliable_queue <= r_ack && r_pkt;
      queue_order       <= order_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CALC))
    else $error("accepted request did not move to calc");

  a_order_step: assert property (@(posedge clk) disable iff (rst)
    calc_done |=> (order_cnt == $past(order_cnt) + 1'b1) && out_valid)
    else $error("queue order did not advance with a result");

  a_calc_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CALC) && !calc_done) |=> (state == ST_CALC) && $stable(order_cnt))
    else $error("calc left without a free output register");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !wr.en)
    else $error("channel memory written while idle");
`endif

endmodule
`default_nettype wire
